// ===== hdl/pilist_pkg.sv =====
// Shared types and codes for the positional insert unique list.
package pilist_pkg;

    // Operation codes carried in s_axis_tuser
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Result status codes carried in m_axis_tuser
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_POS = 2'd1;
    localparam logic [1:0] STATUS_DUP     = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    localparam int KEY_W   = 32;
    localparam int POS_W   = 5;
    localparam int TOTAL_W = 5;
    localparam int RPAY_W  = 32;
    // wide enough for a count up to the largest supported capacity (256)
    localparam int CNT_W   = 9;

    // Broadcast from the control to every cell of the chain
    typedef struct packed {
        logic                    ins;    // commit an insert this cycle
        logic [POS_W-1:0]        pos;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } pilist_ctl_t;

endpackage

// ===== hdl/pilist_cell.sv =====
// One slot of the list: holds a key and payload, shifts up from its lower neighbor.
module pilist_cell #(
    parameter int IDX          = 0,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pilist_pkg::pilist_ctl_t           ctl,
    input  logic [PAYLOAD_BITS-1:0]           ins_payload,
    input  logic signed [pilist_pkg::KEY_W-1:0] prev_key,
    input  logic [PAYLOAD_BITS-1:0]           prev_payload,
    output logic signed [pilist_pkg::KEY_W-1:0] key,
    output logic [PAYLOAD_BITS-1:0]           payload,
    output logic                              match
);
    import pilist_pkg::*;

    localparam logic [CNT_W-1:0] IDX_V = CNT_W'(IDX);

    logic signed [KEY_W-1:0]   key_reg;
    logic signed [KEY_W-1:0]   key_next;
    logic [PAYLOAD_BITS-1:0]   payload_reg;
    logic [PAYLOAD_BITS-1:0]   payload_next;
    logic                      match_reg;
    logic                      match_next;
    logic [CNT_W-1:0]          pos_ext;
    logic                      live;

    assign pos_ext = CNT_W'(ctl.pos);
    assign live    = IDX_V < ctl.count;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        match_next   = live && (key_reg == ctl.key);
        if (ctl.ins && (IDX_V == pos_ext))
        begin
            key_next     = ctl.key;
            payload_next = ins_payload;
        end
        else if (ctl.ins && (IDX_V > pos_ext) && (IDX_V <= ctl.count))
        begin
            key_next     = prev_key;
            payload_next = prev_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign match   = match_reg;

endmodule

// ===== hdl/positional_insert_unique_list_top.sv =====
// Top level: control sequencer and chain of list cells.
//
// Ordered list of up to CAPACITY entries (signed 32-bit key plus PAYLOAD_BITS payload),
// held in a chain of cells. Each operation runs through the phases idle, compare and
// commit: the transfer is captured, every cell compares its key against the request in
// parallel, and then the result is decided and inserts shift the cells above the position
// up by one in a single step. A new transfer is taken as soon as the previous one has
// committed, and not before, so operations never overlap; the result sits in an output
// register and does not block the next transfer unless it is still untaken at the
// following commit. Stored slots need no clearing after reset; a clear only zeroes the fill count.
module positional_insert_unique_list_top #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // position[4:0], new_key[36:5], new_payload[68:37]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // entry_total[4:0], read_key[36:5], read_payload[68:37]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import pilist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_CMP    = 2'd1;
    localparam logic [1:0] PH_COMMIT = 2'd2;

    logic [1:0]              phase_reg, phase_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [1:0]              func_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic [TOTAL_W-1:0]      out_total_reg, out_total_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic [RPAY_W-1:0]       out_pay_reg, out_pay_next;

    logic                    s_fire;
    logic                    commit;
    logic                    dup;
    logic                    ins_ok;
    logic [CNT_W-1:0]        cnt_ext;
    logic [CNT_W-1:0]        pos_ext;
    logic [AW-1:0]           rd_idx;
    pilist_ctl_t             ctl;

    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];
    logic [CAPACITY-1:0]     cell_match;

    assign s_axis_tready = (phase_reg == PH_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign commit        = (phase_reg == PH_COMMIT) && (!out_valid_reg || m_axis_tready);

    assign cnt_ext = CNT_W'(count_reg);
    assign pos_ext = CNT_W'(pos_reg);
    assign rd_idx  = AW'(pos_reg);
    assign dup     = |cell_match;
    assign ins_ok  = (func_reg == FUNC_INSERT) && !(pos_ext > cnt_ext) && !dup
                     && (cnt_ext != CAP_V);

    assign ctl.ins   = commit && ins_ok;
    assign ctl.pos   = pos_reg;
    assign ctl.key   = key_reg;
    assign ctl.count = cnt_ext;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [KEY_W-1:0] prev_key;
            logic [PAYLOAD_BITS-1:0] prev_pay;
            if (g == 0)
            begin : g_first
                assign prev_key = '0;
                assign prev_pay = '0;
            end
            else
            begin : g_rest
                assign prev_key = cell_key[g-1];
                assign prev_pay = cell_pay[g-1];
            end
            pilist_cell #(
                .IDX          (g),
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .ins_payload  (pay_reg),
                .prev_key     (prev_key),
                .prev_payload (prev_pay),
                .key          (cell_key[g]),
                .payload      (cell_pay[g]),
                .match        (cell_match[g])
            );
        end
    endgenerate

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        out_key_next    = out_key_reg;
        out_pay_next    = out_pay_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (s_fire)
                begin
                    phase_next = PH_CMP;
                end
            end
            PH_CMP:
            begin
                phase_next = PH_COMMIT;
            end
            PH_COMMIT:
            begin
                if (commit)
                begin
                    phase_next      = PH_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_key_next    = '0;
                    out_pay_next    = '0;
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                out_status_next = STATUS_BAD_POS;
                            end
                            else if (dup)
                            begin
                                out_status_next = STATUS_DUP;
                            end
                            else if (cnt_ext == CAP_V)
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FUNC_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                out_key_next = cell_key[rd_idx];
                                out_pay_next = RPAY_W'(cell_pay[rd_idx]);
                            end
                            else
                            begin
                                out_status_next = STATUS_BAD_POS;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            out_status_next = STATUS_OK;
                        end
                    endcase
                    out_total_next = TOTAL_W'(count_next);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            func_reg <= s_axis_tuser;
            pos_reg  <= s_axis_tdata[4:0];
            key_reg  <= s_axis_tdata[36:5];
            pay_reg  <= PAYLOAD_BITS'(s_axis_tdata[68:37]);
        end
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
        out_key_reg    <= out_key_next;
        out_pay_reg    <= out_pay_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_pay_reg, out_key_reg, out_total_reg};

endmodule
